/* src/epc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epc_pkg: shared types and constants for the epicycle phasor chain
// Op codes, register indices, FSM states, the CORDIC angle table and constants.
// ---------------------------------------------------------------------------
package epc_pkg;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    localparam logic [1:0] REG_NUM_CIRCLES = 2'd0;
    localparam logic [1:0] REG_CENTER_X    = 2'd1;
    localparam logic [1:0] REG_CENTER_Y    = 2'd2;

    localparam int CORDIC_ITERS = 16;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADV,
        ST_TRIG,
        ST_OUT
    } state_t;

    function automatic logic [31:0] atan_turn(input logic [3:0] i);
        logic [31:0] a;
        begin
            unique case (i)
                4'd0:  a = 32'h20000000;
                4'd1:  a = 32'h12E4051E;
                4'd2:  a = 32'h09FB385B;
                4'd3:  a = 32'h051111D4;
                4'd4:  a = 32'h028B0D43;
                4'd5:  a = 32'h0145D7E1;
                4'd6:  a = 32'h00A2F61E;
                4'd7:  a = 32'h00517C55;
                4'd8:  a = 32'h0028BE53;
                4'd9:  a = 32'h00145F2F;
                4'd10: a = 32'h000A2F98;
                4'd11: a = 32'h000517CC;
                4'd12: a = 32'h00028BE6;
                4'd13: a = 32'h000145F3;
                4'd14: a = 32'h0000A2FA;
                default: a = 32'h0000517D;
            endcase
            return a;
        end
    endfunction

endpackage

/* src/epc_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epc_cell: one circle cell
// Holds a circle's radius and phase. The circular shift line hands phase and
// radius on to the neighbouring cell each cycle the chain rotates.
// ---------------------------------------------------------------------------
module epc_cell (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        shift,
    input  logic        phase_wr,
    input  logic [31:0] phase_wdata,
    input  logic        radius_wr,
    input  logic [15:0] radius_wdata,
    input  logic [31:0] phase_in,
    input  logic [15:0] radius_in,
    output logic [31:0] phase_out,
    output logic [15:0] radius_out
);

    logic [31:0] phase_reg;
    logic [31:0] phase_next;
    logic [15:0] radius_reg;
    logic [15:0] radius_next;

    always_comb begin
        phase_next  = phase_reg;
        radius_next = radius_reg;
        if (shift) begin
            phase_next  = phase_in;
            radius_next = radius_in;
        end
        if (phase_wr) begin
            phase_next = phase_wdata;
        end
        if (radius_wr) begin
            radius_next = radius_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            radius_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            radius_reg <= radius_next;
        end
    end

    assign phase_out  = phase_reg;
    assign radius_out = radius_reg;

endmodule

/* src/epc_cordic.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epc_cordic: iterative sine/cosine unit
// Quadrant reduction, 16 CORDIC rotations one per cycle, Q1.15 rounding.
// ---------------------------------------------------------------------------
module epc_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        phase,
    output logic               done,
    output logic signed [15:0] cos_q15,
    output logic signed [15:0] sin_q15
);

    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [1:0]         q_reg, q_next;
    logic [4:0]         it_reg, it_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [15:0] c_reg, c_next;
    logic signed [15:0] s_reg, s_next;

    logic [31:0]        qsum;
    logic [31:0]        rem;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    logic signed [15:0] cr;
    logic signed [15:0] sr;

    function automatic logic signed [15:0] rnd(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [19:0] h;
        begin
            t = 35'(v) + 35'sd16384;
            h = 20'(t >>> 15);
            if (h > 20'sd32767) return 16'sd32767;
            if (h < -20'sd32768) return -16'sd32768;
            return h[15:0];
        end
    endfunction

    always_comb begin
        qsum = phase + 32'h20000000;
        rem  = phase - {qsum[31:30], 30'd0};
        dx   = y_reg >>> it_reg[3:0];
        dy   = x_reg >>> it_reg[3:0];
        at   = 34'($signed({2'b00, epc_pkg::atan_turn(it_reg[3:0])}));
        cr   = rnd(x_reg);
        sr   = rnd(y_reg);

        x_next = x_reg; y_next = y_reg; z_next = z_reg; q_next = q_reg;
        it_next = it_reg; busy_next = busy_reg; done_next = 1'b0;
        c_next = c_reg; s_next = s_reg;

        if (start) begin
            q_next    = qsum[31:30];
            x_next    = epc_pkg::CORDIC_X0;
            y_next    = '0;
            z_next    = 34'($signed(rem));
            it_next   = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (it_reg == 5'(epc_pkg::CORDIC_ITERS)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                unique case (q_reg)
                    2'd0: begin c_next = cr;  s_next = sr;  end
                    2'd1: begin c_next = -sr; s_next = cr;  end
                    2'd2: begin c_next = -cr; s_next = -sr; end
                    default: begin c_next = sr; s_next = -cr; end
                endcase
            end else begin
                if (!z_reg[33]) begin
                    x_next = x_reg - dx; y_next = y_reg + dy; z_next = z_reg - at;
                end else begin
                    x_next = x_reg + dx; y_next = y_reg - dy; z_next = z_reg + at;
                end
                it_next = it_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next; q_reg <= q_next;
        c_reg <= c_next; s_reg <= s_next;
    end

    assign done    = done_reg;
    assign cos_q15 = c_reg;
    assign sin_q15 = s_reg;

endmodule

/* src/epicycle_phasor_chain.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epicycle_phasor_chain: Fourier epicycle point generator
// Chain of circle cells rotated past a single CORDIC and accumulator.
// ---------------------------------------------------------------------------
// A load beat writes one circle radius by its index. A tick beat walks the
// active circles: each circle at the head of the cell chain has its phase
// advanced, runs through the 16-step iterative CORDIC, and its point is
// summed and presented on the m_ channel; the chain then rotates one place.
// Each circle goes through the phase advance, the CORDIC iterations, then
// the output beat and the rotation, which wait while the output is held
// off; after the active circles the chain is rotated round to its home
// position.
// Input is taken only while no tick is in progress.
module epicycle_phasor_chain #(
    parameter int MAX_CIRCLES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // circle_index[5:0], radius_value[21:6], phase_step[53:22]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // point_index[5:0], point_x[30:6], point_y[55:31]
    output logic        m_tlast
);

    localparam int CW = $clog2(MAX_CIRCLES + 1);

    logic [31:0] ph   [MAX_CIRCLES];
    logic [15:0] rad  [MAX_CIRCLES];

    epc_pkg::state_t state_reg, state_next;
    logic [6:0]  ncfg_reg;
    logic signed [23:0] cx_reg, cy_reg;
    logic [CW-1:0] n_reg, n_next;
    logic [6:0]  k_reg, k_next;      // circle index being processed
    logic [CW-1:0] rot_reg, rot_next; // rotations done this tick
    logic [31:0] step_reg;
    logic [31:0] mul_reg;
    logic signed [24:0] px_reg, px_next, py_reg, py_next;
    logic        ov_reg, ov_next;
    logic [5:0]  oi_reg, oi_next;
    logic        ol_reg, ol_next;
    logic        homing_reg, homing_next;
    logic [1:0]  sub_reg, sub_next;

    logic        shift;
    logic        head_wr;
    logic [31:0] head_wdata;
    logic        cstart, cdone;
    logic signed [15:0] cc, cs;
    logic [5:0]  mag;
    logic [6:0]  ncl;
    logic signed [31:0] tx, ty;
    logic        acc_x;
    logic [5:0]  ld_idx;

    assign ld_idx = s_tdata[5:0];

    genvar g;
    generate
        for (g = 0; g < MAX_CIRCLES; g++) begin : g_cell
            logic wr_r;
            assign wr_r = s_tvalid && s_tready && (s_tuser == epc_pkg::OP_LOAD)
                && (32'(ld_idx) == 32'(g));
            epc_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .shift(shift),
                .phase_wr(head_wr && (g == 0)), .phase_wdata(head_wdata),
                .radius_wr(wr_r), .radius_wdata(s_tdata[21:6]),
                .phase_in(ph[(g + 1) % MAX_CIRCLES]),
                .radius_in(rad[(g + 1) % MAX_CIRCLES]),
                .phase_out(ph[g]), .radius_out(rad[g])
            );
        end
    endgenerate

    epc_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cstart), .phase(head_wdata),
        .done(cdone), .cos_q15(cc), .sin_q15(cs)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncfg_reg <= '0; cx_reg <= '0; cy_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                epc_pkg::REG_NUM_CIRCLES: ncfg_reg <= cfg_wdata[6:0];
                epc_pkg::REG_CENTER_X:    cx_reg   <= cfg_wdata;
                epc_pkg::REG_CENTER_Y:    cy_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ncl = (ncfg_reg > 7'(MAX_CIRCLES)) ? 7'(MAX_CIRCLES) : ncfg_reg;
    assign mag = 6'((k_reg + 7'd1) >> 1);

    // product term: radius * trig (Q1.15), rounded back to the radius scale
    assign tx = $signed({1'b0, rad[0]}) * cc;
    assign ty = $signed({1'b0, rad[0]}) * cs;

    function automatic logic signed [24:0] r15(input logic signed [31:0] p);
        logic signed [32:0] t;
        begin
            t = 33'(p) + 33'sd16384;
            return 25'(t >>> 15);
        end
    endfunction

    assign acc_x = 1'b0;

    always_comb begin
        state_next = state_reg; n_next = n_reg; k_next = k_reg; rot_next = rot_reg;
        px_next = px_reg; py_next = py_reg; ov_next = ov_reg; oi_next = oi_reg;
        ol_next = ol_reg; homing_next = homing_reg; sub_next = sub_reg;
        shift = 1'b0; head_wr = 1'b0; cstart = 1'b0;
        head_wdata = k_reg[0] ? ph[0] + mul_reg : ph[0] - mul_reg;
        s_tready = (state_reg == epc_pkg::ST_IDLE) && !acc_x;
        if (m_tready) ov_next = 1'b0;
        unique case (state_reg)
            epc_pkg::ST_IDLE: begin
                if (s_tvalid && s_tuser == epc_pkg::OP_TICK) begin
                    n_next = CW'(ncl);
                    k_next = '0; rot_next = '0;
                    px_next = 25'(cx_reg); py_next = 25'(cy_reg);
                    sub_next = '0;
                    state_next = (ncl == 7'd0) ? epc_pkg::ST_IDLE : epc_pkg::ST_ADV;
                end
            end
            epc_pkg::ST_ADV: begin
                // mul_reg is valid in the cycle after k settles
                if (sub_reg == 2'd0) begin
                    sub_next = 2'd1;
                end else begin
                    sub_next = 2'd0;
                    head_wr = 1'b1; cstart = 1'b1;
                    state_next = epc_pkg::ST_TRIG;
                end
            end
            epc_pkg::ST_TRIG: begin
                if (cdone) begin
                    px_next = px_reg + r15(tx);
                    py_next = py_reg + r15(ty);
                    oi_next = k_reg[5:0];
                    ol_next = (k_reg + 7'd1 == 7'(n_reg));
                    state_next = epc_pkg::ST_OUT;
                end
            end
            default: begin
                if (!ov_reg || m_tready) begin
                    if (!homing_reg) begin
                        ov_next = 1'b1;
                        homing_next = 1'b1;
                    end else begin
                        // rotate chain one place
                        shift = 1'b1;
                        rot_next = rot_reg + 1'b1;
                        k_next = k_reg + 7'd1;
                        if (k_reg + 7'd1 < 7'(n_reg)) begin
                            homing_next = 1'b0;
                            state_next = epc_pkg::ST_ADV;
                        end else if (32'(rot_reg) + 1 == MAX_CIRCLES) begin
                            homing_next = 1'b0;
                            state_next = epc_pkg::ST_IDLE;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= epc_pkg::ST_IDLE;
            ov_reg <= 1'b0; homing_reg <= 1'b0; sub_reg <= '0;
            k_reg <= '0; rot_reg <= '0; n_reg <= '0;
        end else begin
            state_reg <= state_next;
            ov_reg <= ov_next; homing_reg <= homing_next; sub_reg <= sub_next;
            k_reg <= k_next; rot_reg <= rot_next; n_reg <= n_next;
        end
        if (state_reg == epc_pkg::ST_IDLE && s_tvalid && s_tuser == epc_pkg::OP_TICK)
            step_reg <= s_tdata[53:22];
        mul_reg <= 32'(mag) * step_reg;
        px_reg <= px_next; py_reg <= py_next; oi_reg <= oi_next; ol_reg <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {py_reg, px_reg, oi_reg};
    assign m_tlast  = ol_reg;

endmodule

/* verif/epicycle_phasor_chain_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epicycle_phasor_chain_test: self-checking bench for the epicycle chain
// Drives radius loads and ticks with random gaps and back-pressure, predicts
// every chain point with a local CORDIC model and checks each output beat.
// ---------------------------------------------------------------------------
module epicycle_phasor_chain_test;

    localparam int NCIRC = 64;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [5:0]  idx;
        logic [24:0] x;
        logic [24:0] y;
        logic        last;
    } chain_point_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    epicycle_phasor_chain uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic [31:0]        phase_mem [NCIRC];
    logic [15:0]        radius_mem [NCIRC];
    logic [6:0]         active_circles;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    chain_point_t       pending_points[$];

    int  error_count = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    bit  no_gaps = 1'b0;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd15(longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic longint clip15(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic cordic_cos_sin(input logic [31:0] ph, output longint c_o,
                                  output longint s_o);
        logic [31:0] sum;
        logic [1:0]  q;
        longint z, x, y, dx, dy, c, s;
        sum = ph + 32'h20000000;
        q = sum[31:30];
        z = longint'(ph) - longint'(q) * 64'sh40000000;
        x = epc_pkg::CORDIC_X0;
        y = 0;
        if (z >= 64'sh80000000) z -= 64'sh100000000;
        for (int i = 0; i < epc_pkg::CORDIC_ITERS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(epc_pkg::atan_turn(4'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(epc_pkg::atan_turn(4'(i)));
            end
        end
        c = clip15(rnd15(x));
        s = clip15(rnd15(y));
        case (q)
            2'd0: begin c_o = c;  s_o = s;  end
            2'd1: begin c_o = -s; s_o = c;  end
            2'd2: begin c_o = -c; s_o = -s; end
            default: begin c_o = s;  s_o = -c; end
        endcase
    endtask

    task automatic predict_item(input epc_pkg::op_t op, input logic [5:0] ci,
                                input logic [15:0] rv, input logic [31:0] step);
        int n;
        longint px, py, c, s, r;
        logic [31:0] delta;
        chain_point_t p;
        if (op == epc_pkg::OP_LOAD) begin
            radius_mem[ci] = rv;
            return;
        end
        n = (active_circles > NCIRC) ? NCIRC : active_circles;
        px = origin_x;
        py = origin_y;
        for (int k = 0; k < n; k++) begin
            delta = 32'((k + 1) / 2) * step;
            if (k % 2) phase_mem[k] = phase_mem[k] + delta;
            else phase_mem[k] = phase_mem[k] - delta;
            cordic_cos_sin(phase_mem[k], c, s);
            r = radius_mem[k];
            px += rnd15(r * c);
            py += rnd15(r * s);
            p.idx = 6'(k);
            p.x = 25'(px);
            p.y = 25'(py);
            p.last = (k + 1 == n);
            pending_points.push_back(p);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    // s_tvalid stays up after a beat so that a back-to-back beat follows;
    // whoever stops sending drops it
    task automatic send_item(input epc_pkg::op_t op, input logic [5:0] ci,
                             input logic [15:0] rv, input logic [31:0] step);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, step, rv, ci};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(op, ci, rv, step);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        s_tvalid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            epc_pkg::REG_NUM_CIRCLES: active_circles = val[6:0];
            epc_pkg::REG_CENTER_X:    origin_x = val;
            default:                  origin_y = val;
        endcase
        @(posedge aclk);
    endtask

    // wait for all points, then let the chain rotate home
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic random_tick;
        send_item(epc_pkg::OP_TICK, 6'($urandom), 16'($urandom), $urandom);
    endtask

    // receiver
    always @(posedge aclk) begin
        chain_point_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata, 0);
            end else begin
                want = pending_points.pop_front();
                if (m_tdata[5:0] != want.idx) report_mismatch("point_index", m_tdata[5:0], want.idx);
                if (m_tdata[30:6] != want.x) report_mismatch("point_x", m_tdata[30:6], want.x);
                if (m_tdata[55:31] != want.y) report_mismatch("point_y", m_tdata[55:31], want.y);
                if (m_tlast != want.last) report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    initial begin : rx_stall
        int wait_n;
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end else if (no_gaps) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                wait_n = $urandom_range(0, 18);
                if (wait_n != 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_n) @(posedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_directed;
        write_reg(epc_pkg::REG_NUM_CIRCLES, 24'd0);
        send_item(epc_pkg::OP_TICK, 6'd0, 16'd0, 32'h12345678);   // no circles: nothing out
        drain();
        write_reg(epc_pkg::REG_CENTER_X, 24'h7FFFFF);
        write_reg(epc_pkg::REG_CENTER_Y, 24'h800000);
        write_reg(epc_pkg::REG_NUM_CIRCLES, 24'd3);
        send_item(epc_pkg::OP_LOAD, 6'd0, 16'hFFFF, 32'hFFFFFFFF);
        send_item(epc_pkg::OP_LOAD, 6'd1, 16'hFFFF, 32'h0);
        send_item(epc_pkg::OP_LOAD, 6'd2, 16'h8000, 32'h0);
        send_item(epc_pkg::OP_LOAD, 6'd63, 16'h0001, 32'h0);
        send_item(epc_pkg::OP_TICK, 6'd0, 16'd0, 32'h0);
        send_item(epc_pkg::OP_TICK, 6'd0, 16'd0, 32'h40000000);
        send_item(epc_pkg::OP_TICK, 6'd0, 16'd0, 32'h20000000);
        send_item(epc_pkg::OP_TICK, 6'd0, 16'd0, 32'hFFFFFFFF);
        send_item(epc_pkg::OP_TICK, 6'd0, 16'd0, 32'h80000000);
        drain();
        write_reg(epc_pkg::REG_CENTER_X, 24'h800000);
        write_reg(epc_pkg::REG_CENTER_Y, 24'h7FFFFF);
        write_reg(epc_pkg::REG_NUM_CIRCLES, 24'd127);         // clipped to the bank size
        for (int i = 0; i < 4; i++)
            send_item(epc_pkg::OP_LOAD, 6'(i * 21), 16'hFFFF, 32'h0);
        send_item(epc_pkg::OP_TICK, 6'd0, 16'd0, 32'h01000000);
        send_item(epc_pkg::OP_TICK, 6'd0, 16'd0, 32'hFFFFFFFF);
        drain();
        write_reg(epc_pkg::REG_NUM_CIRCLES, 24'd64);
        send_item(epc_pkg::OP_TICK, 6'd0, 16'd0, 32'h0);
        drain();
        write_reg(epc_pkg::REG_NUM_CIRCLES, 24'd1);            // inactive circles keep phase
        send_item(epc_pkg::OP_TICK, 6'd0, 16'd0, 32'h33333333);
        drain();
    endtask

    task automatic test_random;
        for (int phase_i = 0; phase_i < 6; phase_i++) begin
            write_reg(epc_pkg::REG_NUM_CIRCLES,
                      (phase_i == 5) ? 24'd64 : 24'($urandom_range(0, 10)));
            write_reg(epc_pkg::REG_CENTER_X, 24'($urandom));
            write_reg(epc_pkg::REG_CENTER_Y, 24'($urandom));
            no_gaps = (phase_i == 2);
            for (int i = 0; i < 48; i++) begin
                if ($urandom_range(0, 2) == 0) random_tick();
                else send_item(epc_pkg::OP_LOAD, 6'($urandom), 16'($urandom), $urandom);
            end
            no_gaps = 1'b0;
            drain();
        end
    endtask

    task automatic test_backpressure;
        write_reg(epc_pkg::REG_NUM_CIRCLES, 24'd8);
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++) random_tick();
        drain();
    endtask

    initial begin
        for (int i = 0; i < NCIRC; i++) begin
            phase_mem[i] = '0;
            radius_mem[i] = '0;
        end
        active_circles = '0;
        origin_x = '0;
        origin_y = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        if (error_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
